FILE: rtl/fdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the frame
// decoder.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned HDR_FIELDS = 5;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [COUNT_W-1:0] HDR_BYTES  = 9'd7;
  localparam logic [COUNT_W-1:0] MIN_BYTES  = 9'd9;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 9'd511;
  localparam logic [COUNT_W-1:0] IDX_START0 = 9'd0;
  localparam logic [COUNT_W-1:0] IDX_START1 = 9'd1;
  localparam logic [COUNT_W-1:0] IDX_HDR0   = 9'd2;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [BYTE_W-1:0] FIRST_START_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_START_RST = 8'h55;

  localparam logic CFG_FIRST_START  = 1'b0;
  localparam logic CFG_SECOND_START = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_START = 3'd2,
    ST_LEN_ERR   = 3'd3,
    ST_CRC_ERR   = 3'd4
  } fdc_status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } fdc_item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    fdc_status_e       status;
    logic [BYTE_W-1:0] version;
    logic [BYTE_W-1:0] pkt_type;
    logic [BYTE_W-1:0] src_id;
    logic [BYTE_W-1:0] dst_id;
    logic [BYTE_W-1:0] pay_len;
    logic [CRC_W-1:0]  crc_word;
  } fdc_result_t;

  typedef struct packed {
    logic              we;
    logic              idx;
    logic [BYTE_W-1:0] data;
  } fdc_cfg_t;

  function automatic logic [CRC_W-1:0] crc16_fold(logic [CRC_W-1:0] crc,
                                                  logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/fdc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_in_stage
// Input register: captures one byte transaction and holds it until the
// parser takes it.
// ----------------------------------------------------------------------------
module fdc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fdc_pkg::fdc_item_t in_item_i,
  input  logic              take_i,
  output logic              valid_o,
  output fdc_pkg::fdc_item_t item_o
);
  import fdc_pkg::*;

  logic      valid_q, valid_d;
  fdc_item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/fdc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_parser
// Frame state, start byte registers, header capture, running CRC and the
// end-of-frame status. One byte is consumed per step.
// ----------------------------------------------------------------------------
module fdc_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fdc_pkg::fdc_cfg_t    cfg_i,
  input  logic                 step_i,
  input  fdc_pkg::fdc_item_t   item_i,
  output logic                 res_valid_o,
  output fdc_pkg::fdc_result_t res_o
);
  import fdc_pkg::*;

  logic [BYTE_W-1:0]  first_start_q, second_start_q;
  logic [COUNT_W-1:0] byte_count_q, byte_count_d;
  logic               start_match_q, start_match_d;
  logic [CRC_W-1:0]   crc_q, crc_d;
  logic [BYTE_W-1:0]  held0_q, held0_d, held1_q, held1_d;
  logic [BYTE_W-1:0]  hdr_q [HDR_FIELDS];
  logic [BYTE_W-1:0]  hdr_d [HDR_FIELDS];

  logic [COUNT_W-1:0] idx, total, pay_idx, frame_len;
  logic [CRC_W-1:0]   rx_crc;
  logic [BYTE_W-1:0]  b;
  logic               is_payload;
  fdc_status_e        status;

  always_comb begin
    b   = item_i.data_byte;
    idx = byte_count_q;

    start_match_d = start_match_q;
    if ((idx == IDX_START0 && b != first_start_q) ||
        (idx == IDX_START1 && b != second_start_q)) begin
      start_match_d = 1'b0;
    end

    for (int i = 0; i < HDR_FIELDS; i++) begin
      hdr_d[i] = hdr_q[i];
      if (idx == IDX_HDR0 + COUNT_W'(i)) begin
        hdr_d[i] = b;
      end
    end

    crc_d   = (idx >= IDX_HDR0) ? crc16_fold(crc_q, held0_q) : crc_q;
    rx_crc  = {b, held1_q};
    held0_d = held1_q;
    held1_d = b;

    total        = (idx < COUNT_MAX) ? idx + 9'd1 : COUNT_MAX;
    byte_count_d = total;

    pay_idx    = idx - HDR_BYTES;
    frame_len  = MIN_BYTES + {1'b0, hdr_d[HDR_FIELDS-1]};
    is_payload = start_match_d && (idx >= HDR_BYTES) &&
                 (pay_idx < {1'b0, hdr_d[HDR_FIELDS-1]});

    if (total < MIN_BYTES) begin
      status = ST_TOO_SHORT;
    end else if (!start_match_d) begin
      status = ST_BAD_START;
    end else if (total != frame_len) begin
      status = ST_LEN_ERR;
    end else if (crc_d != rx_crc) begin
      status = ST_CRC_ERR;
    end else begin
      status = ST_OK;
    end

    res_o = '0;
    res_valid_o = 1'b0;
    if (item_i.last) begin
      res_valid_o        = 1'b1;
      res_o.kind         = KIND_REPORT;
      res_o.status       = status;
      res_o.version      = hdr_d[0];
      res_o.pkt_type     = hdr_d[1];
      res_o.src_id       = hdr_d[2];
      res_o.dst_id       = hdr_d[3];
      res_o.pay_len      = hdr_d[4];
      res_o.crc_word     = rx_crc;
      byte_count_d       = '0;
      start_match_d      = 1'b1;
      crc_d              = CRC_INIT;
      held0_d            = '0;
      held1_d            = '0;
      for (int i = 0; i < HDR_FIELDS; i++) begin
        hdr_d[i] = '0;
      end
    end else if (is_payload) begin
      res_valid_o        = 1'b1;
      res_o.kind         = KIND_PAYLOAD;
      res_o.payload_byte = b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_start_q  <= FIRST_START_RST;
      second_start_q <= SECOND_START_RST;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CFG_FIRST_START) begin
        first_start_q <= cfg_i.data;
      end else begin
        second_start_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      start_match_q <= 1'b1;
      crc_q         <= CRC_INIT;
      held0_q       <= '0;
      held1_q       <= '0;
      for (int i = 0; i < HDR_FIELDS; i++) begin
        hdr_q[i] <= '0;
      end
    end else if (step_i) begin
      byte_count_q  <= byte_count_d;
      start_match_q <= start_match_d;
      crc_q         <= crc_d;
      held0_q       <= held0_d;
      held1_q       <= held1_d;
      for (int i = 0; i < HDR_FIELDS; i++) begin
        hdr_q[i] <= hdr_d[i];
      end
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last |=> byte_count_q == '0 && start_match_q && crc_q == CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(byte_count_q) && $stable(crc_q))
    else $error("frame state moved without a step");

  a_payload_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_PAYLOAD |-> start_match_q && byte_count_q >= HDR_BYTES)
    else $error("payload forwarded outside a matching frame body");

endmodule

FILE: rtl/fdc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module fdc_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fdc_pkg::fdc_result_t res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fdc_pkg::fdc_result_t res_o
);
  import fdc_pkg::*;

  logic        valid_q, valid_d;
  fdc_result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/frame_decoder_crc16_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_decoder_crc16_check
// Byte-stream frame decoder with start byte check, cut-through payload
// forwarding and CRC-16/MODBUS verification.
//
//   channel  dir  tdata                                  tuser / tlast
//   s_axis   in   [7:0] data_byte                        tlast: last
//   m_axis   out  [7:0] payload_byte, [10:8] status,     tuser: kind
//                 [18:11] version, [26:19] pkt_type,
//                 [34:27] src_id, [42:35] dst_id,
//                 [50:43] pay_len, [66:51] crc_word
//   cfg      in   index 0 first start byte, 1 second start byte
//
// One byte per cycle while results are taken, via input and result registers.
// The CRC register update (eight folded bit steps) sets the cycle path.
// Reset clears the frame state and loads start bytes 0xAA and 0x55.
// A stalled result holds the result register; the input register still
// takes one byte, then input ready drops until the result moves.
// ----------------------------------------------------------------------------
module frame_decoder_crc16_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [fdc_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [fdc_pkg::OUT_DATA_W-1:0] m_axis_tdata, // payload_byte, status,
                                                       // version, pkt_type,
                                                       // src_id, dst_id,
                                                       // pay_len,
                                                       // crc_word
  output logic                         m_axis_tuser,   // [0] kind
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [fdc_pkg::BYTE_W-1:0]   cfg_data_i
);
  import fdc_pkg::*;

  fdc_item_t   in_item, stage_item;
  fdc_result_t res, out_res;
  fdc_cfg_t    cfg;
  logic        stage_valid, take, res_valid, out_free;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.last      = s_axis_tlast;
  assign cfg.we            = cfg_we_i;
  assign cfg.idx           = cfg_idx_i;
  assign cfg.data          = cfg_data_i;

  assign take = stage_valid && out_free;

  fdc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  fdc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (take),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fdc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {5'b00000, out_res.crc_word, out_res.pay_len,
                         out_res.dst_id, out_res.src_id, out_res.pkt_type,
                         out_res.version, out_res.status, out_res.payload_byte};

endmodule
